@@ rtl/ssa_pkg.sv @@
// ----------------------------------------------------------------------------
// Stack sample aggregator package
// Shared sizes, hash constants, outcome codes and control types.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int MAX_FRAMES  = 16;
  localparam int FRAME_W     = $clog2(MAX_FRAMES);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [2:0] OUT_NEW     = 3'd0;
  localparam logic [2:0] OUT_HIT     = 3'd1;
  localparam logic [2:0] OUT_LIMIT   = 3'd2;
  localparam logic [2:0] OUT_SAT     = 3'd3;
  localparam logic [2:0] OUT_NO_SLOT = 3'd4;

  typedef struct packed {
    logic init;
    logic step;
  } fnv_ctl_t;

endpackage

@@ rtl/stack_sample_aggregator_unit.sv @@
// ----------------------------------------------------------------------------
// Stack sample aggregator
// Counts distinct call stacks in a linear-probing hash table.
// ----------------------------------------------------------------------------
// After reset all 4096 entries of the count store are swept to zero with in_ready_o
// low. Non-final words of a sample are taken whenever the unit is idle. The final word
// starts a sequence on one shared FNV multiply unit and single-port tables:
// hashing of the five key words and the frames, the home slot, a read and a check per
// probed slot plus a read and a check per compared frame, a store of all 16 frame slots
// of a new entry, and a load of the result register. Input is not taken while this runs.
module stack_sample_aggregator_unit import ssa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] thread_id_i,
  input  logic [31:0] thread_generation_i,
  input  logic [7:0]  cpu_index_i,
  input  logic        sample_kind_i,
  input  logic [4:0]  frame_depth_i,
  input  logic [31:0] frame_address_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  outcome_o,
  output logic [11:0] slot_index_o,
  output logic [31:0] slot_count_o,
  output logic [31:0] total_samples_o,
  output logic [12:0] total_stacks_o,
  output logic [31:0] total_dropped_o
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_HASH  = 10'b0000000100,
    S_HOME  = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_CHK   = 10'b0000100000,
    S_FRD   = 10'b0001000000,
    S_FCHK  = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [SLOT_W-1:0]  clr_q, idx_q;
  logic [SLOT_W:0]    probe_q;
  logic [4:0]         elem_q, w_q, k_q;
  logic [31:0]        pend_q [MAX_FRAMES];
  logic [31:0]        tid_q, gen_q, cnt_q;
  logic [13:0]        info_q;
  logic [31:0]        sample_q, drop_q;
  logic [12:0]        stack_q, limit_q;
  logic [2:0]         res_out_q;
  logic [SLOT_W-1:0]  res_slot_q;
  logic [31:0]        res_cnt_q;
  logic               out_valid_q;

  logic        in_acc;
  logic [4:0]  depth_in, depth, fidx, w_sub;
  logic [31:0] fdata, word, hash;
  fnv_ctl_t    fnv_ctl;

  logic [SLOT_W-1:0]           slot_addr;
  logic [SLOT_W+FRAME_W-1:0]   frame_addr;
  logic        cnt_we, key_we, frame_we;
  logic [31:0] cnt_wdata, cnt_rd, tid_rd, gen_rd, frame_rd, frame_wdata;
  logic [13:0] info_rd;
  logic        empty, at_limit, keym, new_wr, hit0, fmatch, hitf, probe_end, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign depth_in   = (frame_depth_i > 5'(MAX_FRAMES)) ? 5'(MAX_FRAMES) : frame_depth_i;
  assign depth      = info_q[13:9];

  assign w_sub = w_q - 5'd5;
  assign fidx  = (state_q == S_HASH) ? w_sub : k_q;
  assign fdata = (fidx < elem_q) ? pend_q[fidx[FRAME_W-1:0]] : '0;

  always_comb begin
    case (w_q)
      5'd0:    word = tid_q;
      5'd1:    word = gen_q;
      5'd2:    word = {24'd0, info_q[7:0]};
      5'd3:    word = {31'd0, info_q[8]};
      5'd4:    word = {27'd0, depth};
      default: word = fdata;
    endcase
  end

  assign fnv_ctl.init = in_acc && last_element_i;
  assign fnv_ctl.step = (state_q == S_HASH);

  ssa_fnv_unit u_fnv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fnv_ctl),
    .word_i (word),
    .hash_o (hash)
  );

  assign empty     = (cnt_rd == '0);
  assign at_limit  = (stack_q >= limit_q);
  assign keym      = (tid_rd == tid_q) && (gen_rd == gen_q) && (info_rd == info_q);
  assign new_wr    = (state_q == S_CHK) && empty && !at_limit;
  assign hit0      = (state_q == S_CHK) && !empty && keym && (depth == 5'd0);
  assign fmatch    = (frame_rd == fdata);
  assign hitf      = (state_q == S_FCHK) && fmatch && (k_q == depth - 5'd1);
  assign probe_end = (probe_q == (SLOT_W+1)'(TABLE_DEPTH - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  assign slot_addr   = (state_q == S_CLEAR) ? clr_q : idx_q;
  assign frame_addr  = {idx_q, k_q[FRAME_W-1:0]};
  assign cnt_we      = (state_q == S_CLEAR) || new_wr || hit0 || hitf;
  assign key_we      = new_wr;
  assign frame_we    = (state_q == S_WRITE);
  assign frame_wdata = (k_q < depth) ? fdata : '0;

  always_comb begin
    if (state_q == S_CLEAR) begin
      cnt_wdata = '0;
    end else if (new_wr) begin
      cnt_wdata = 32'd1;
    end else if (hit0) begin
      cnt_wdata = cnt_rd + 32'd1;
    end else begin
      cnt_wdata = cnt_q + 32'd1;
    end
  end

  ssa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk_i(clk_i), .we_i(cnt_we), .addr_i(slot_addr), .wdata_i(cnt_wdata), .rdata_o(cnt_rd)
  );
  ssa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tid_ram (
    .clk_i(clk_i), .we_i(key_we), .addr_i(slot_addr), .wdata_i(tid_q), .rdata_o(tid_rd)
  );
  ssa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_gen_ram (
    .clk_i(clk_i), .we_i(key_we), .addr_i(slot_addr), .wdata_i(gen_q), .rdata_o(gen_rd)
  );
  ssa_ram #(.WIDTH(14), .DEPTH(TABLE_DEPTH)) u_info_ram (
    .clk_i(clk_i), .we_i(key_we), .addr_i(slot_addr), .wdata_i(info_q), .rdata_o(info_rd)
  );
  ssa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH * MAX_FRAMES)) u_frame_ram (
    .clk_i(clk_i), .we_i(frame_we), .addr_i(frame_addr), .wdata_i(frame_wdata),
    .rdata_o(frame_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == SLOT_W'(TABLE_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc && last_element_i) state_d = S_HASH;
      S_HASH:  if (w_q == depth + 5'd4) state_d = S_HOME;
      S_HOME:  state_d = (sample_q == '1) ? S_FIN : S_RD;
      S_RD:    state_d = S_CHK;
      S_CHK: begin
        if (empty) begin
          state_d = at_limit ? S_FIN : S_WRITE;
        end else if (keym) begin
          state_d = (depth == 5'd0) ? S_FIN : S_FRD;
        end else begin
          state_d = probe_end ? S_FIN : S_RD;
        end
      end
      S_FRD:   state_d = S_FCHK;
      S_FCHK: begin
        if (!fmatch) begin
          state_d = probe_end ? S_FIN : S_RD;
        end else if (hitf) begin
          state_d = S_FIN;
        end else begin
          state_d = S_FRD;
        end
      end
      S_WRITE: if (k_q == 5'(MAX_FRAMES - 1)) state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      elem_q      <= '0;
      sample_q    <= '0;
      stack_q     <= '0;
      drop_q      <= '0;
      limit_q     <= 13'd3072;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (in_acc && elem_q < 5'(MAX_FRAMES)) elem_q <= elem_q + 5'd1;
      if (new_wr) stack_q <= stack_q + 13'd1;
      if (new_wr || hit0 || hitf) sample_q <= sample_q + 32'd1;
      if (state_q == S_FIN && out_free) begin
        elem_q      <= '0;
        out_valid_q <= 1'b1;
        if (res_out_q >= OUT_LIMIT) drop_q <= drop_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && elem_q < 5'(MAX_FRAMES)) begin
      pend_q[elem_q[FRAME_W-1:0]] <= frame_address_i;
    end
    if (in_acc && last_element_i) begin
      tid_q  <= thread_id_i;
      gen_q  <= thread_generation_i;
      info_q <= {depth_in, sample_kind_i, cpu_index_i};
      w_q    <= '0;
    end
    if (state_q == S_HASH) w_q <= w_q + 5'd1;
    if (state_q == S_HOME) begin
      idx_q      <= hash[SLOT_W-1:0];
      probe_q    <= '0;
      res_out_q  <= OUT_SAT;
      res_slot_q <= '0;
      res_cnt_q  <= '0;
    end
    if (state_q == S_CHK) begin
      cnt_q <= cnt_rd;
      k_q   <= '0;
      if (empty) begin
        if (at_limit) begin
          res_out_q <= OUT_LIMIT;
        end else begin
          res_out_q  <= OUT_NEW;
          res_slot_q <= idx_q;
          res_cnt_q  <= 32'd1;
        end
      end else if (hit0) begin
        res_out_q  <= OUT_HIT;
        res_slot_q <= idx_q;
        res_cnt_q  <= cnt_rd + 32'd1;
      end
    end
    if ((state_q == S_CHK && !empty && !keym) || (state_q == S_FCHK && !fmatch)) begin
      idx_q   <= idx_q + 1'b1;
      probe_q <= probe_q + 1'b1;
      if (probe_end) res_out_q <= OUT_NO_SLOT;
    end
    if (state_q == S_FCHK && fmatch) begin
      k_q <= k_q + 5'd1;
      if (hitf) begin
        res_out_q  <= OUT_HIT;
        res_slot_q <= idx_q;
        res_cnt_q  <= cnt_q + 32'd1;
      end
    end
    if (state_q == S_WRITE) k_q <= k_q + 5'd1;
    if (state_q == S_FIN && out_free) begin
      outcome_o       <= res_out_q;
      slot_index_o    <= 12'(res_slot_q);
      slot_count_o    <= res_cnt_q;
      total_samples_o <= sample_q;
      total_stacks_o  <= stack_q;
      total_dropped_o <= (res_out_q >= OUT_LIMIT) ? drop_q + 32'd1 : drop_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_new_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_NEW |-> slot_count_o == 32'd1)
    else $error("new entry with count other than one");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_LIMIT || outcome_o == OUT_SAT ||
    outcome_o == OUT_NO_SLOT) |-> slot_index_o == '0 && slot_count_o == '0)
    else $error("dropped word with nonzero slot fields");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_q <= 13'(TABLE_DEPTH))
    else $error("stack total above table depth");

  a_table_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> !at_limit && state_q == S_CHK)
    else $error("key written past the entry limit");

endmodule

@@ rtl/ssa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/ssa_fnv_unit.sv @@
// ----------------------------------------------------------------------------
// FNV-1a mixing unit
// Holds the running hash and folds in one 32-bit word per step.
// ----------------------------------------------------------------------------
module ssa_fnv_unit import ssa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fnv_ctl_t    ctl_i,
  input  logic [31:0] word_i,
  output logic [31:0] hash_o
);

  logic [31:0] hash_q, hash_d;
  logic [63:0] prod;

  assign prod = 64'(hash_q ^ word_i) * 64'(FNV_PRIME);

  always_comb begin
    hash_d = hash_q;
    if (ctl_i.init) begin
      hash_d = FNV_BASIS;
    end else if (ctl_i.step) begin
      hash_d = prod[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;

endmodule

@@ test/stack_sample_aggregator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack sample aggregator checker
// Watches the input, output and register ports, keeps its own copy of the
// stack table and compares every output word with the expected outcome.
// ----------------------------------------------------------------------------
module stack_sample_aggregator_checker import ssa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] thread_id_i,
  input  logic [31:0] thread_generation_i,
  input  logic [7:0]  cpu_index_i,
  input  logic        sample_kind_i,
  input  logic [4:0]  frame_depth_i,
  input  logic [31:0] frame_address_i,
  input  logic        last_element_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  outcome_i,
  input  logic [11:0] slot_index_i,
  input  logic [31:0] slot_count_i,
  input  logic [31:0] total_samples_i,
  input  logic [12:0] total_stacks_i,
  input  logic [31:0] total_dropped_i,
  output int          pending_o,
  output int          errors_o,
  output int          hits_o,
  output int          drops_o
);

  typedef struct packed {
    logic [2:0]  outcome;
    logic [11:0] slot;
    logic [31:0] count;
    logic [31:0] samples;
    logic [12:0] stacks;
    logic [31:0] dropped;
  } tally_t;

  tally_t      tally_q[$];
  logic [12:0] limit_q;
  logic [31:0] cnt_mem [TABLE_DEPTH];
  logic [31:0] tid_mem [TABLE_DEPTH];
  logic [31:0] gen_mem [TABLE_DEPTH];
  logic [13:0] info_mem[TABLE_DEPTH];
  logic [31:0] frm_mem [TABLE_DEPTH][MAX_FRAMES];
  logic [31:0] pend_frm[MAX_FRAMES];
  int unsigned word_cnt;
  logic [31:0] n_samples, n_dropped;
  logic [12:0] n_stacks;

  assign pending_o = tally_q.size();

  function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [31:0] w);
    return (h ^ w) * FNV_PRIME;
  endfunction

  function automatic bit key_equal(int s, logic [31:0] tid, logic [31:0] gen,
                                   logic [13:0] info, int dep);
    if (tid_mem[s] != tid || gen_mem[s] != gen || info_mem[s] != info) return 0;
    for (int k = 0; k < dep; k++)
      if (frm_mem[s][k] != pend_frm[k]) return 0;
    return 1;
  endfunction

  task automatic clear_table();
    for (int s = 0; s < TABLE_DEPTH; s++) cnt_mem[s] = '0;
    for (int k = 0; k < MAX_FRAMES; k++) pend_frm[k] = '0;
    word_cnt  = 0;
    n_samples = '0;
    n_dropped = '0;
    n_stacks  = '0;
    limit_q   = 13'd3072;
  endtask

  task automatic record_word();
    int          dep, idx;
    logic [31:0] h;
    logic [13:0] info;
    tally_t      t;
    bit          done;
    if (word_cnt < MAX_FRAMES) begin
      pend_frm[word_cnt] = frame_address_i;
      word_cnt++;
    end
    if (!last_element_i) return;
    dep  = (frame_depth_i > MAX_FRAMES) ? MAX_FRAMES : frame_depth_i;
    info = {dep[4:0], sample_kind_i, cpu_index_i};
    h = FNV_BASIS;
    h = fnv_mix(h, thread_id_i);
    h = fnv_mix(h, thread_generation_i);
    h = fnv_mix(h, {24'd0, cpu_index_i});
    h = fnv_mix(h, {31'd0, sample_kind_i});
    h = fnv_mix(h, dep);
    for (int k = 0; k < dep; k++) h = fnv_mix(h, pend_frm[k]);
    t = '0;
    done = 0;
    if (n_samples == 32'hFFFF_FFFF) begin
      t.outcome = OUT_SAT;
      done = 1;
    end
    idx = h % TABLE_DEPTH;
    for (int p = 0; !done && p < TABLE_DEPTH; p++) begin
      if (cnt_mem[idx] == 0) begin
        if (n_stacks >= limit_q) begin
          t.outcome = OUT_LIMIT;
        end else begin
          tid_mem[idx]  = thread_id_i;
          gen_mem[idx]  = thread_generation_i;
          info_mem[idx] = info;
          for (int k = 0; k < MAX_FRAMES; k++)
            frm_mem[idx][k] = (k < dep) ? pend_frm[k] : '0;
          cnt_mem[idx] = 1;
          n_stacks++;
          n_samples++;
          t.outcome = OUT_NEW;
          t.slot    = 12'(idx);
          t.count   = 1;
        end
        done = 1;
      end else if (key_equal(idx, thread_id_i, thread_generation_i, info, dep)) begin
        cnt_mem[idx]++;
        n_samples++;
        t.outcome = OUT_HIT;
        t.slot    = 12'(idx);
        t.count   = cnt_mem[idx];
        done = 1;
      end else begin
        idx = (idx + 1) % TABLE_DEPTH;
      end
    end
    if (!done) t.outcome = OUT_NO_SLOT;
    if (t.outcome == OUT_HIT) hits_o++;
    if (t.outcome >= OUT_LIMIT) begin
      n_dropped++;
      drops_o++;
    end
    for (int k = 0; k < MAX_FRAMES; k++) pend_frm[k] = '0;
    word_cnt  = 0;
    t.samples = n_samples;
    t.stacks  = n_stacks;
    t.dropped = n_dropped;
    tally_q.push_back(t);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t t;
    if (!rst_ni) begin
      clear_table();
      tally_q.delete();
      errors_o = 0;
      hits_o   = 0;
      drops_o  = 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) record_word();
      if (out_valid_i && out_ready_i) begin
        if (tally_q.size() == 0) begin
          report("unexpected word", 1, 0);
        end else begin
          t = tally_q.pop_front();
          if (outcome_i != t.outcome)       report("outcome", outcome_i, t.outcome);
          if (slot_index_i != t.slot)       report("slot_index", slot_index_i, t.slot);
          if (slot_count_i != t.count)      report("slot_count", slot_count_i, t.count);
          if (total_samples_i != t.samples) report("total_samples", total_samples_i, t.samples);
          if (total_stacks_i != t.stacks)   report("total_stacks", total_stacks_i, t.stacks);
          if (total_dropped_i != t.dropped) report("total_dropped", total_dropped_i, t.dropped);
        end
      end
    end
  end

endmodule

@@ test/stack_sample_aggregator_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack sample aggregator testbench
// Sends directed and random profiler samples, many of them repeats from a
// small stack pool, under several entry limits with random stalls on both
// channels outside the last phase; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module stack_sample_aggregator_unit_test;
  import ssa_pkg::*;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [12:0] cfg_wdata_i = '0;
  logic        in_valid_i = 0, in_ready_o;
  logic [31:0] thread_id_i = '0, thread_generation_i = '0, frame_address_i = '0;
  logic [7:0]  cpu_index_i = '0;
  logic        sample_kind_i = 0, last_element_i = 0;
  logic [4:0]  frame_depth_i = '0;
  logic        out_valid_o, out_ready_i = 0;
  logic [2:0]  outcome_o;
  logic [11:0] slot_index_o;
  logic [31:0] slot_count_o, total_samples_o, total_dropped_o;
  logic [12:0] total_stacks_o;
  int          pending, errors, hits, drops;
  int          n_words, n_samples;
  bit          quiet;

  typedef struct {
    logic [31:0] tid, gen;
    logic [7:0]  cpu;
    logic        kind;
    logic [4:0]  depth;
    int          n_words;
    logic [31:0] frames[20];
  } sample_t;

  sample_t pool[12];

  stack_sample_aggregator_unit u_dut (.*);

  stack_sample_aggregator_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .thread_id_i, .thread_generation_i, .cpu_index_i,
    .sample_kind_i, .frame_depth_i, .frame_address_i, .last_element_i,
    .out_valid_i(out_valid_o), .out_ready_i, .outcome_i(outcome_o),
    .slot_index_i(slot_index_o), .slot_count_i(slot_count_o),
    .total_samples_i(total_samples_o), .total_stacks_i(total_stacks_o),
    .total_dropped_i(total_dropped_o), .pending_o(pending), .errors_o(errors),
    .hits_o(hits), .drops_o(drops)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1;
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    int r;
    s.tid   = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom();
    s.gen   = $urandom();
    s.cpu   = 8'($urandom());
    s.kind  = 1'($urandom());
    r = $urandom_range(0, 9);
    s.depth = (r == 0) ? 5'($urandom_range(17, 31)) :
              (r < 3)  ? 5'd0 : 5'($urandom_range(1, 8));
    s.n_words = (s.depth == 0) ? 1 : (s.depth > 16) ? 16 : s.depth;
    r = $urandom_range(0, 9);
    if (r == 0) s.n_words = $urandom_range(1, 20);
    foreach (s.frames[i]) s.frames[i] = $urandom();
    return s;
  endfunction

  task automatic send_word(sample_t s, int i);
    bit last;
    last = (i == s.n_words - 1);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i          <= 1;
    thread_id_i         <= last ? s.tid   : $urandom();
    thread_generation_i <= last ? s.gen   : $urandom();
    cpu_index_i         <= last ? s.cpu   : 8'($urandom());
    sample_kind_i       <= last ? s.kind  : 1'($urandom());
    frame_depth_i       <= last ? s.depth : 5'($urandom());
    frame_address_i     <= s.frames[i];
    last_element_i      <= last;
    do @(posedge clk_i); while (!in_ready_o);
    n_words++;
  endtask

  task automatic send_sample(sample_t s);
    for (int i = 0; i < s.n_words; i++) send_word(s, i);
    n_samples++;
  endtask

  task automatic drain_and_set(logic [12:0] lim);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic random_phase(int n_items);
    sample_t s;
    int      k, start;
    start = n_words;
    while (n_words - start < n_items) begin
      k = $urandom_range(0, 11);
      if ($urandom_range(0, 9) < 6) begin
        s = pool[k];
      end else begin
        s = rand_sample();
        if ($urandom_range(0, 2) == 0) pool[k] = s;
      end
      send_sample(s);
    end
  endtask

  initial begin
    sample_t s;
    foreach (pool[i]) pool[i] = rand_sample();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= 13'd4096;
    @(posedge clk_i);
    cfg_we_i <= 0;

    // directed: extremes, depth zero, saturated depth, short and long samples
    s = rand_sample();
    s.tid = '0; s.gen = '0; s.cpu = '0; s.kind = 0; s.depth = 0; s.n_words = 1;
    s.frames[0] = 32'hFFFF_FFFF;
    send_sample(s);
    send_sample(s);
    s.tid = '1; s.gen = '1; s.cpu = '1; s.kind = 1; s.depth = 5'd31; s.n_words = 18;
    foreach (s.frames[i]) s.frames[i] = '1;
    send_sample(s);
    s.depth = 5'd16; s.n_words = 3;
    send_sample(s);
    send_sample(s);

    drain_and_set(13'd0);
    random_phase(150);
    drain_and_set(13'd6);
    random_phase(250);
    drain_and_set(13'd4096);
    random_phase(350);
    drain_and_set(13'd3072);
    random_phase(250);
    quiet = 1;
    random_phase(120);

    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words in %0d samples under entry limits 0, 6, 4096 and 3072;",
             n_words, n_samples);
    $display("seen %0d hits and %0d dropped samples.", hits, drops);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ssa_pkg.sv
rtl/ssa_ram.sv
rtl/ssa_fnv_unit.sv
rtl/stack_sample_aggregator_unit.sv
test/stack_sample_aggregator_checker.sv
test/stack_sample_aggregator_unit_test.sv
